FILE: rtl/assert_macros.svh
// Assertion macros used by the block's RTL (mtws_dp).
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MTWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MTWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/mtws_pkg.sv
// Shared constants and controller/datapath command and status types.
// No dependencies.
package mtws_pkg;

    localparam int SUM_W   = 26;
    localparam int BEST_W  = 28;
    localparam int LEN_W   = 11;
    localparam int START_W = 10;
    localparam int FOUND_W = 2;

    // commands from controller to datapath
    typedef struct packed {
        logic ld_issue;
        logic ld_finish;
        logic fill_init;
        logic fill_wr;
        logic tr_init;
        logic tr_rd;
        logic tr_ev;
        logic emit;
    } mtws_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last;
        logic fill_more;
        logic trace_more;
        logic out_free;
    } mtws_status_t;

endpackage

FILE: rtl/mtws_ifs.sv
// Valid/ready channel interfaces: sample input, result output, config write.
// Depends on mtws_pkg for field widths.
interface mtws_in_if #(parameter int SAMPLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface mtws_out_if;
    import mtws_pkg::*;
    logic               valid;
    logic               ready;
    logic [START_W-1:0] first_start;
    logic [START_W-1:0] second_start;
    logic [START_W-1:0] third_start;
    logic [FOUND_W-1:0] found_count;
    logic               overflowed;
    modport source (output valid, output first_start, output second_start,
                    output third_start, output found_count, output overflowed,
                    input ready);
    modport sink (input valid, input first_start, input second_start,
                  input third_start, input found_count, input overflowed,
                  output ready);
endinterface

interface mtws_cfg_if;
    import mtws_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/mtws_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mtws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/mtws_ctrl.sv
// Sequencer for load, table fill, trace back and result hand-off.
// Depends on mtws_pkg.
module mtws_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mtws_pkg::mtws_status_t status,
    output mtws_pkg::mtws_cmd_t    cmd
);
    import mtws_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LOAD      = 4'd1;
    localparam logic [3:0] S_FILL_INIT = 4'd2;
    localparam logic [3:0] S_FILL_RD   = 4'd3;
    localparam logic [3:0] S_FILL_WR   = 4'd4;
    localparam logic [3:0] S_TR_INIT   = 4'd5;
    localparam logic [3:0] S_TR_RD     = 4'd6;
    localparam logic [3:0] S_TR_EV     = 4'd7;
    localparam logic [3:0] S_EMIT      = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.ld_issue = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.ld_finish = 1'b1;
                state_next    = status.last ? S_FILL_INIT : S_IDLE;
            end
            S_FILL_INIT:
            begin
                cmd.fill_init = 1'b1;
                state_next    = S_FILL_RD;
            end
            S_FILL_RD:
            begin
                state_next = status.fill_more ? S_FILL_WR : S_TR_INIT;
            end
            S_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = S_FILL_RD;
            end
            S_TR_INIT:
            begin
                cmd.tr_init = 1'b1;
                state_next  = S_TR_RD;
            end
            S_TR_RD:
            begin
                cmd.tr_rd  = 1'b1;
                state_next = status.trace_more ? S_TR_EV : S_EMIT;
            end
            S_TR_EV:
            begin
                cmd.tr_ev  = 1'b1;
                state_next = S_TR_RD;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/mtws_dp.sv
// Datapath: sample and window-sum stores, best-total layers, trace back, output register.
// Depends on mtws_pkg, mtws_ram and assert_macros.svh.
`include "assert_macros.svh"
module mtws_dp #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtws_pkg::mtws_cmd_t           cmd,
    output mtws_pkg::mtws_status_t        status,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic                          last,
    input  logic                          cfg_valid,
    input  logic [mtws_pkg::LEN_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mtws_pkg::START_W-1:0]  first_start,
    output logic [mtws_pkg::START_W-1:0]  second_start,
    output logic [mtws_pkg::START_W-1:0]  third_start,
    output logic [mtws_pkg::FOUND_W-1:0]  found_count,
    output logic                          overflowed
);
    import mtws_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int WW    = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 2;

    function automatic logic [START_W-1:0] to_start(input logic [IDX_W-1:0] x);
        logic [31:0] tmp;
        tmp = 32'(x);
        return tmp[START_W-1:0];
    endfunction

    logic [LEN_W-1:0]       len_reg;
    logic [CNT_W-1:0]       count_reg, m_reg, i_reg;
    logic [SUM_W-1:0]       rs_reg;
    logic                   ovf_reg, held_reg, last_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [1:0]             r_reg, found_reg;
    logic [BEST_W-1:0]      prev1_reg, prev2_reg, prev3_reg;
    logic [IDX_W-1:0]       pick_reg [3];
    logic                   out_valid_reg;
    logic [START_W-1:0]     first_reg, second_reg, third_reg;
    logic [FOUND_W-1:0]     found_out_reg;
    logic                   ovf_out_reg;

    // wide views for compares
    logic [LEN_W-1:0] k;
    logic [WW-1:0]    k_w, cnt_w, i_w;
    assign k     = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign k_w   = WW'(k);
    assign cnt_w = WW'(count_reg);
    assign i_w   = WW'(i_reg);

    // memories
    logic [SAMPLE_BITS-1:0] st_rd;
    logic [SUM_W-1:0]       ws_rd, rs_new;
    logic [BEST_W-1:0]      l1_rd, l2_rd, l3_rd;
    logic                   st_we, ws_we, lay_we;
    logic [WW-1:0]          st_ra_w, ws_wa_w, a_ik_w, a_i2_w, a_i1_w;
    logic [IDX_W-1:0]       a_ik, a_i2;
    logic [BEST_W-1:0]      new1, new2, new3;

    assign st_we   = cmd.ld_issue && (count_reg < CNT_W'(MAX_SAMPLES));
    assign st_ra_w = cnt_w - k_w;
    assign ws_wa_w = cnt_w + WW'(1) - k_w;
    assign ws_we   = cmd.ld_finish && held_reg && (cnt_w + WW'(1) >= k_w);
    assign a_ik_w  = i_w - k_w - WW'(1);
    assign a_i2_w  = i_w - WW'(2);
    assign a_i1_w  = i_w - WW'(1);
    assign a_ik    = a_ik_w[IDX_W-1:0];
    assign a_i2    = a_i2_w[IDX_W-1:0];
    assign lay_we  = cmd.fill_wr;

    mtws_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
        .clk(clk), .we(st_we), .waddr(count_reg[IDX_W-1:0]), .wdata(sample),
        .raddr(st_ra_w[IDX_W-1:0]), .rdata(st_rd));

    mtws_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SAMPLES)) u_wsum (
        .clk(clk), .we(ws_we), .waddr(ws_wa_w[IDX_W-1:0]), .wdata(rs_new),
        .raddr(a_i1_w[IDX_W-1:0]), .rdata(ws_rd));

    // layer j holds row i at address i-1; row zero is implied zero
    mtws_ram #(.WIDTH(BEST_W), .DEPTH(MAX_SAMPLES)) u_lay1 (
        .clk(clk), .we(lay_we), .waddr(a_i1_w[IDX_W-1:0]), .wdata(new1),
        .raddr((cmd.tr_rd && r_reg != 2'd2) ? a_i2 : a_ik), .rdata(l1_rd));

    mtws_ram #(.WIDTH(BEST_W), .DEPTH(MAX_SAMPLES)) u_lay2 (
        .clk(clk), .we(lay_we), .waddr(a_i1_w[IDX_W-1:0]), .wdata(new2),
        .raddr((cmd.tr_rd && r_reg != 2'd3) ? a_i2 : a_ik), .rdata(l2_rd));

    mtws_ram #(.WIDTH(BEST_W), .DEPTH(MAX_SAMPLES)) u_lay3 (
        .clk(clk), .we(lay_we), .waddr(a_i1_w[IDX_W-1:0]), .wdata(new3),
        .raddr(a_i2), .rdata(l3_rd));

    // running sum update
    logic [SUM_W-1:0] sub_val;
    assign sub_val = (cnt_w >= k_w) ? SUM_W'(st_rd) : '0;
    assign rs_new  = rs_reg + SUM_W'(smp_reg) - sub_val;

    // fill row: take vs skip per layer
    logic              i_gt_k, i_ge_k, i_gt_1;
    logic [BEST_W-1:0] w_ext, t1, t2, t3;
    assign i_gt_k = i_w > k_w;
    assign i_ge_k = i_w >= k_w;
    assign i_gt_1 = i_w > WW'(1);
    assign w_ext  = BEST_W'(ws_rd);
    assign t1     = w_ext;
    assign t2     = w_ext + (i_gt_k ? l1_rd : '0);
    assign t3     = w_ext + (i_gt_k ? l2_rd : '0);
    assign new1   = (t1 > prev1_reg) ? t1 : prev1_reg;
    assign new2   = (t2 > prev2_reg) ? t2 : prev2_reg;
    assign new3   = (t3 > prev3_reg) ? t3 : prev3_reg;

    // trace step compare
    logic [BEST_W-1:0] lo_sel, hi_sel, tt, ss;
    logic              take;
    always_comb
    begin
        unique case (r_reg)
            2'd3:
            begin
                lo_sel = l2_rd;
                hi_sel = l3_rd;
            end
            2'd2:
            begin
                lo_sel = l1_rd;
                hi_sel = l2_rd;
            end
            default:
            begin
                lo_sel = '0;
                hi_sel = l1_rd;
            end
        endcase
    end
    assign tt   = w_ext + (i_gt_k ? lo_sel : '0);
    assign ss   = i_gt_1 ? hi_sel : '0;
    assign take = tt > ss;

    logic [WW-1:0] i_sub_k, m_w;
    assign i_sub_k = i_w - k_w;
    assign m_w     = cnt_w - k_w + WW'(1);

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            len_reg <= cfg_data;
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rs_reg        <= '0;
            ovf_reg       <= 1'b0;
            held_reg      <= 1'b0;
            last_reg      <= 1'b0;
            m_reg         <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ld_issue)
            begin
                held_reg <= st_we;
                last_reg <= last;
                if (!st_we)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.ld_finish && held_reg)
            begin
                rs_reg    <= rs_new;
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.fill_init)
            begin
                m_reg <= (cnt_w >= k_w) ? m_w[CNT_W-1:0] : '0;
                i_reg <= CNT_W'(1);
            end
            if (cmd.fill_wr)
            begin
                i_reg <= i_reg + CNT_W'(1);
            end
            if (cmd.tr_init)
            begin
                i_reg     <= m_reg;
                r_reg     <= 2'd3;
                found_reg <= '0;
            end
            if (cmd.tr_ev)
            begin
                if (take)
                begin
                    found_reg <= found_reg + 2'd1;
                    r_reg     <= r_reg - 2'd1;
                    i_reg     <= i_ge_k ? i_sub_k[CNT_W-1:0] : '0;
                end
                else
                begin
                    i_reg <= i_reg - CNT_W'(1);
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= '0;
                rs_reg        <= '0;
                ovf_reg       <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_issue)
        begin
            smp_reg <= sample;
        end
        if (cmd.fill_init)
        begin
            prev1_reg <= '0;
            prev2_reg <= '0;
            prev3_reg <= '0;
        end
        if (cmd.fill_wr)
        begin
            prev1_reg <= new1;
            prev2_reg <= new2;
            prev3_reg <= new3;
        end
        if (cmd.tr_ev && take)
        begin
            pick_reg[found_reg] <= a_i1_w[IDX_W-1:0];
        end
        if (cmd.emit)
        begin
            found_out_reg <= found_reg;
            ovf_out_reg   <= ovf_reg;
            unique case (found_reg)
                2'd3:
                begin
                    first_reg  <= to_start(pick_reg[2]);
                    second_reg <= to_start(pick_reg[1]);
                    third_reg  <= to_start(pick_reg[0]);
                end
                2'd2:
                begin
                    first_reg  <= to_start(pick_reg[1]);
                    second_reg <= to_start(pick_reg[0]);
                    third_reg  <= '0;
                end
                2'd1:
                begin
                    first_reg  <= to_start(pick_reg[0]);
                    second_reg <= '0;
                    third_reg  <= '0;
                end
                default:
                begin
                    first_reg  <= '0;
                    second_reg <= '0;
                    third_reg  <= '0;
                end
            endcase
        end
    end

    assign status.last       = last_reg;
    assign status.fill_more  = i_reg <= m_reg;
    assign status.trace_more = (i_reg != '0) && (r_reg != 2'd0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign first_start  = first_reg;
    assign second_start = second_reg;
    assign third_start  = third_reg;
    assign found_count  = found_out_reg;
    assign overflowed   = ovf_out_reg;

    // row writes stay inside the window-start range
    `MTWS_ASSERT_NOW(a_fill_in_range, clk, rst_n, cmd.fill_wr, i_reg <= m_reg && i_reg != '0)
    // a take always has a free pick slot
    `MTWS_ASSERT_NOW(a_pick_slot, clk, rst_n, cmd.tr_ev && take, found_reg != 2'd3)
    // an emit leaves a valid result and a cleared sample count
    `MTWS_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_reg && count_reg == '0)
endmodule

FILE: rtl/max_three_window_sum_select_top.sv
// Top level of the best-three-window selector.
// Depends on mtws_pkg, mtws_ifs, mtws_ctrl, mtws_dp, mtws_ram.
//
// Usage:
//   in_ch  : sample stream (sample, last); one transfer per valid & ready.
//   cfg    : window length write; always ready, write only while idle.
//   out_ch : one result per sequence (three starts, count, overflow flag).
// Each sample takes an issue and a finish state, set by the sample store's
// registered read of the sample leaving the window. Samples beyond
// MAX_SAMPLES are dropped and flag overflow; a last mark on them still
// ends the sequence. After last, with m window starts: setup, a read and a
// write per window start to fill the three best-total layers (reading each
// layer's older row), a read to leave the fill, trace setup, a read and an
// evaluate per trace-back step (at most m steps), a read to leave the
// trace, then the output register load. The next sequence may load while a
// result waits; if the receiver stalls, the following result holds the
// block until the output register frees. Reset clears counters, the
// running sum and the output valid; window length resets to 1.
module max_three_window_sum_select_top #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mtws_in_if.sink    in_ch,
    mtws_out_if.source out_ch,
    mtws_cfg_if.sink   cfg
);
    import mtws_pkg::*;

    mtws_cmd_t    cmd;
    mtws_status_t status;

    assign cfg.ready = 1'b1;

    mtws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mtws_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (in_ch.sample),
        .last         (in_ch.last),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .first_start  (out_ch.first_start),
        .second_start (out_ch.second_start),
        .third_start  (out_ch.third_start),
        .found_count  (out_ch.found_count),
        .overflowed   (out_ch.overflowed)
    );
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the best-three-window selector.
// Depends on mtws_pkg, mtws_ifs and max_three_window_sum_select_top from the RTL.
// A directed table runs first, then random sequences checked against an in-bench predictor.
module tb_top;
    import mtws_pkg::*;

    localparam int CAP = 1024;
    localparam longint unsigned SUM_MASK = (64'd1 << SUM_W) - 1;

    typedef struct packed {
        logic [START_W-1:0] first_start;
        logic [START_W-1:0] second_start;
        logic [START_W-1:0] third_start;
        logic [FOUND_W-1:0] found_count;
        logic               overflowed;
    } pick_t;

    typedef struct {
        logic [15:0] sample;
        logic        last;
        bit          typed;
        pick_t       want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    bit   failed;
    int   items_sent;

    mtws_in_if #(.SAMPLE_BITS(16)) in_ch ();
    mtws_out_if out_ch ();
    mtws_cfg_if cfg_ch ();

    max_three_window_sum_select_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state: samples, window sums, prefix table, counters
    longint unsigned held_samples[CAP];
    longint unsigned win_sums[CAP];
    longint unsigned best_tot[CAP+1][4];
    longint unsigned run_sum;
    longint unsigned held_count;
    bit              dropped;
    logic [LEN_W-1:0] win_len;

    pick_t pending_picks[$];

    always #6 clk = ~clk;

    function automatic longint unsigned take_sum(longint unsigned i, int r, longint unsigned k);
        longint unsigned v;
        v = win_sums[i-1];
        if (i >= k)
            v += best_tot[i-k][r-1];
        return v;
    endfunction

    // Fill the best-total table and trace back; ties skip to the earlier start
    function automatic pick_t select_windows();
        longint unsigned k, m, i, t, s;
        longint unsigned picks[3];
        int r, found;
        pick_t res;
        k = (win_len == 0) ? 1 : win_len;
        m = (held_count >= k) ? held_count - k + 1 : 0;
        found = 0;
        for (r = 0; r < 4; r++)
            best_tot[0][r] = 0;
        for (i = 1; i <= m; i++)
        begin
            best_tot[i][0] = 0;
            for (r = 1; r <= 3; r++)
            begin
                t = take_sum(i, r, k);
                s = best_tot[i-1][r];
                best_tot[i][r] = (t > s) ? t : s;
            end
        end
        i = m;
        r = 3;
        while (i > 0 && r > 0)
        begin
            t = take_sum(i, r, k);
            s = best_tot[i-1][r];
            if (t > s)
            begin
                picks[found] = i - 1;
                found++;
                r--;
                i = (i >= k) ? i - k : 0;
            end
            else
                i--;
        end
        res = '0;
        if (found > 0) res.first_start  = START_W'(picks[found-1]);
        if (found > 1) res.second_start = START_W'(picks[found-2]);
        if (found > 2) res.third_start  = START_W'(picks[0]);
        res.found_count = FOUND_W'(found);
        res.overflowed  = dropped;
        run_sum    = 0;
        held_count = 0;
        dropped    = 0;
        return res;
    endfunction

    // Advance the predictor by one accepted sample
    function automatic bit absorb_sample(logic [15:0] smp, logic lst, output pick_t res);
        longint unsigned k;
        k = (win_len == 0) ? 1 : win_len;
        res = '0;
        if (held_count < CAP)
        begin
            held_samples[held_count] = smp;
            run_sum += smp;
            if (held_count + 1 > k)
                run_sum -= held_samples[held_count - k];
            run_sum &= SUM_MASK;
            if (held_count + 1 >= k)
                win_sums[held_count + 1 - k] = run_sum;
            held_count++;
        end
        else
            dropped = 1;
        if (!lst)
            return 0;
        res = select_windows();
        return 1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One sample transfer; valid stays high across back-to-back items
    bit no_gaps;
    task automatic send_sample(logic [15:0] smp, logic lst, bit typed, pick_t want);
        int gap;
        pick_t res;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= smp;
        in_ch.last   <= lst;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
        if (absorb_sample(smp, lst, res))
            pending_picks.insert(pending_picks.size(), typed ? want : res);
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Window length write while the block is idle
    task automatic write_len(logic [LEN_W-1:0] v);
        drop_valid();
        while (pending_picks.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        win_len = v;
        @(posedge clk);
    endtask

    task automatic send_sequence(int n, int mode);
        logic [15:0] smp;
        int j;
        for (j = 0; j < n; j++)
        begin
            case (mode)
                0: smp = $urandom_range(0, 65535);
                1: smp = 16'h0000;
                2: smp = $urandom_range(0, 3);
                default: smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            send_sample(smp, j == n - 1, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, compare each transfer with the oldest expectation
    int stall_left;
    bit stall_free;
    always @(posedge clk)
    begin
        pick_t got, exp_pick;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.first_start, out_ch.second_start, out_ch.third_start,
                    out_ch.found_count, out_ch.overflowed};
            if (pending_picks.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                failed = 1;
            end
            else
            begin
                exp_pick = pending_picks.pop_front();
                if (got !== exp_pick)
                begin
                    $display("%0t: result mismatch expected %p actual %p", $time, exp_pick, got);
                    failed = 1;
                end
            end
        end
        if ($urandom_range(0, 63) == 0)
            stall_free = ~stall_free;
        if (stall_left > 0)
            stall_left--;
        else if (!stall_free)
            stall_left = pick_gap();
        out_ch.ready <= rst_n && (stall_free || stall_left == 0);
    end

    // Stimulus
    initial
    begin
        plan_row_t plan[];
        logic [LEN_W-1:0] lens[];
        int p, q, n, kk;
        bit big_done;

        plan = '{
            '{16'hFFFF, 1'b1, 1'b1, '{10'd0, 10'd0, 10'd0, 2'd1, 1'b0}},
            '{16'h0000, 1'b1, 1'b1, '{10'd0, 10'd0, 10'd0, 2'd0, 1'b0}},
            '{16'd5,    1'b0, 1'b0, '0},
            '{16'd0,    1'b0, 1'b0, '0},
            '{16'd7,    1'b1, 1'b1, '{10'd0, 10'd2, 10'd0, 2'd2, 1'b0}},
            '{16'd1,    1'b0, 1'b0, '0},
            '{16'd2,    1'b0, 1'b0, '0},
            '{16'd3,    1'b0, 1'b0, '0},
            '{16'd4,    1'b1, 1'b0, '0},
            '{16'hAAAA, 1'b0, 1'b0, '0},
            '{16'h5555, 1'b0, 1'b0, '0},
            '{16'h8001, 1'b1, 1'b0, '0}
        };
        lens = '{11'd3, 11'd0, 11'd2, 11'd1024, 11'd5,
                 11'd2047, 11'd1, 11'd4, 11'd7, 11'd2};
        clk = 0;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.sample = '0;
        in_ch.last = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        run_sum = 0;
        held_count = 0;
        dropped = 0;
        win_len = 1;
        big_done = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table at the reset window length
        no_gaps = 0;
        foreach (plan[i])
            send_sample(plan[i].sample, plan[i].last, plan[i].typed, plan[i].want);

        // Random phases, one window length each
        p = 0;
        while (items_sent < 1600)
        begin
            write_len(lens[p % lens.size()]);
            kk = (win_len == 0) ? 1 : win_len;
            if (win_len == 1024 && !big_done)
            begin
                // Overrun the sample store; one window fits, the rest is dropped
                big_done = 1;
                no_gaps = 1;
                send_sequence(1030, 0);
            end
            for (q = 0; q < 12; q++)
            begin
                no_gaps = ($urandom_range(0, 3) == 0);
                if (kk > 64 || $urandom_range(0, 7) == 0)
                    n = $urandom_range(1, (kk > 8) ? 8 : kk);
                else
                    n = kk + $urandom_range(0, 14);
                send_sequence(n, ($urandom_range(0, 5) < 3) ? 0 : $urandom_range(1, 3));
            end
            p++;
        end
        drop_valid();

        while (pending_picks.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(12 * 900000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: max_three_window_sum_select_top.f
+incdir+rtl
rtl/mtws_pkg.sv
rtl/mtws_ifs.sv
rtl/mtws_ram.sv
rtl/mtws_ctrl.sv
rtl/mtws_dp.sv
rtl/max_three_window_sum_select_top.sv
tb/sv/tb_top.sv
